@@ rtl/assert_macros.svh @@
// Assertion helpers for the bound checker pcg32_chk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/pcg32_pkg.sv @@
`default_nettype none
package pcg32_pkg;

  localparam int STATE_W = 64;
  localparam int WORD_W  = 32;
  localparam int STEP_W  = $clog2(STATE_W);
  localparam int ROT_W   = $clog2(WORD_W);

  localparam logic [STATE_W-1:0] LCG_MULT   = 64'd6364136223846793005;
  localparam logic [STATE_W-1:0] STATE_INIT = 64'h853c49e6748fea9b;
  localparam logic [STATE_W-1:0] INC_INIT   = 64'hda3e39cb94b95bdb;
  localparam logic [WORD_W-1:0]  MASK_INIT  = 32'h7fffffff;

  // XSH-RR taps
  localparam int XSH_SHIFT = 18;
  localparam int XSH_LOW   = 27;
  localparam int ROT_LOW   = 59;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASK = 2'd1;

  typedef enum logic [1:0] {
    MODE_RAW    = 2'd0,
    MODE_MASKED = 2'd1,
    MODE_RANGED = 2'd2,
    MODE_RESEED = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } fsm_t;

  // Xorshift-high then rotate right by the top five state bits.
  function automatic logic [WORD_W-1:0] permute(input logic [STATE_W-1:0] s);
    logic [STATE_W-1:0] x;
    logic [WORD_W-1:0]  mixed;
    logic [ROT_W-1:0]   amount;
    x      = s ^ (s >> XSH_SHIFT);
    mixed  = x[XSH_LOW +: WORD_W];
    amount = s[ROT_LOW +: ROT_W];
    permute = (mixed >> amount) | (mixed << (ROT_W'(0) - amount));
  endfunction

endpackage
`default_nettype wire

@@ rtl/pcg32_random_generator.sv @@
// Channel   | Handshake            | Payload
// ----------+----------------------+--------------------------------------
// request   | req_valid / req_stall| mode, range_low, range_high
// result    | res_valid / res_stall| value
// config    | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// After a request is taken, the LCG advances bit-serially, one multiplier bit per
// step through a 64-bit shift-add, with the 32-step restoring modulo running in
// the first half of the advance; a done step then forms the result. The next
// request is taken only once the block is back in idle, never while one is in work.
// Reset is synchronous and active high; it restores state, increment and registers.
// A stalled result holds its slot; the next request parks in its final step.
`default_nettype none
module pcg32_random_generator (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire logic [1:0]         mode,
  input  wire logic signed [31:0] range_low,
  input  wire logic signed [31:0] range_high,
  output logic                    res_valid,
  input  wire logic               res_stall,
  output logic [31:0]             value,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [pcg32_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]        cfg_data
);

  localparam int SW = pcg32_pkg::STATE_W;
  localparam int WW = pcg32_pkg::WORD_W;
  localparam int NW = pcg32_pkg::STEP_W;

  pcg32_pkg::fsm_t  fsm;
  pcg32_pkg::mode_t mode_q;

  logic [SW-1:0] lcg_state;     // shifts right; product bits enter at the top
  logic [SW-1:0] lcg_increment;
  logic [SW-1:0] acc;           // running partial sum of the multiply
  logic [NW-1:0] cnt;
  logic [WW-1:0] seed_value;
  logic [WW-1:0] rand_mask;
  logic [WW-1:0] raw;           // rotates left during the modulo, back intact after
  logic [WW-1:0] rem;
  logic [WW-1:0] span;
  logic [WW-1:0] low_q;

  logic [SW:0]   mul_sum;
  logic [WW:0]   div_trial;
  logic [WW:0]   div_diff;
  logic [WW-1:0] rem_next;
  logic [SW-1:0] seed_inc;
  logic [WW-1:0] result;
  logic          slot_free;
  logic          accept;

  assign req_stall = rst | (fsm != pcg32_pkg::ST_IDLE);
  assign cfg_ready = ~rst;
  assign accept    = req_valid & ~req_stall;
  assign slot_free = ~res_valid | ~res_stall;

  // Reseed increment: (seed << 1) | 1
  assign seed_inc = {{(SW-WW-1){1'b0}}, seed_value, 1'b1};

  // One multiplier bit per cycle; the lowest bit of the sum is final.
  assign mul_sum = {1'b0, acc} + (lcg_state[0] ? {1'b0, pcg32_pkg::LCG_MULT} : '0);

  // Restoring modulo step. A zero span subtracts nothing, so rem ends as raw,
  // which is exactly the full-range case.
  assign div_trial = {rem, raw[WW-1]};
  assign div_diff  = div_trial - {1'b0, span};
  assign rem_next  = div_diff[WW] ? div_trial[WW-1:0] : div_diff[WW-1:0];

  always_comb begin
    case (mode_q)
      pcg32_pkg::MODE_RAW:    result = raw;
      pcg32_pkg::MODE_MASKED: result = raw & rand_mask;
      pcg32_pkg::MODE_RANGED: result = rem + low_q;
      default:                result = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm           <= pcg32_pkg::ST_IDLE;
      res_valid     <= 1'b0;
      lcg_state     <= pcg32_pkg::STATE_INIT;
      lcg_increment <= pcg32_pkg::INC_INIT;
      seed_value    <= '0;
      rand_mask     <= pcg32_pkg::MASK_INIT;
      cnt           <= '0;
    end else begin
      // configuration writes; indexes past the list are dropped
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == pcg32_pkg::REG_SEED) seed_value <= cfg_data;
        if (cfg_index == pcg32_pkg::REG_MASK) rand_mask  <= cfg_data;
      end

      // drop a taken result; the done step refills the slot on its own
      if (res_valid && !res_stall && fsm != pcg32_pkg::ST_DONE) res_valid <= 1'b0;

      case (fsm)
        pcg32_pkg::ST_IDLE: begin
          if (accept) begin
            mode_q <= pcg32_pkg::mode_t'(mode);
            low_q  <= $unsigned(range_low);
            span   <= $unsigned(range_high) - $unsigned(range_low) + WW'(1);
            raw    <= pcg32_pkg::permute(lcg_state);
            rem    <= '0;
            cnt    <= '0;
            if (pcg32_pkg::mode_t'(mode) == pcg32_pkg::MODE_RESEED) begin
              // first advance from zero state yields the increment itself
              lcg_increment <= seed_inc;
              lcg_state     <= seed_inc + {{(SW-WW){1'b0}}, seed_value};
              acc           <= seed_inc;
            end else begin
              acc <= lcg_increment;
            end
            fsm <= pcg32_pkg::ST_RUN;
          end
        end
        pcg32_pkg::ST_RUN: begin
          lcg_state <= {mul_sum[0], lcg_state[SW-1:1]};
          acc       <= mul_sum[SW:1];
          if (!cnt[NW-1]) begin
            rem <= rem_next;
            raw <= {raw[WW-2:0], raw[WW-1]};
          end
          cnt <= cnt + NW'(1);
          if (cnt == NW'(SW-1)) fsm <= pcg32_pkg::ST_DONE;
        end
        pcg32_pkg::ST_DONE: begin
          // hold until the result register can take the new value
          if (slot_free) begin
            value     <= result;
            res_valid <= 1'b1;
            fsm       <= pcg32_pkg::ST_IDLE;
          end
        end
        default: fsm <= pcg32_pkg::ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/pcg32_chk.sv @@
`default_nettype none
`include "assert_macros.svh"
module pcg32_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_stall,
  input wire logic        res_valid,
  input wire logic        res_stall,
  input wire logic [31:0] value
);

  // an accepted request keeps the block busy on the next cycle
  `ASSERT_NEXT(a_busy_after_req, clk, rst, req_valid && !req_stall, req_stall)

  // a new result only comes out of work in progress
  `ASSERT_SAME(a_res_from_work, clk, rst, $rose(res_valid), $past(req_stall))

  // a result never appears right after acceptance
  `ASSERT_NEXT(a_no_instant_res, clk, rst, req_valid && !req_stall, !$rose(res_valid))

  // stalled result holds
  `ASSERT_NEXT(a_res_hold, clk, rst, res_valid && res_stall, res_valid && $stable(value))

endmodule

bind pcg32_random_generator pcg32_chk u_pcg32_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .value     (value)
);
`default_nettype wire

@@ sim/pcg32_checker.sv @@
`timescale 1ns / 100ps
module pcg32_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  input  logic                             req_stall,
  input  logic [1:0]                       mode,
  input  logic [31:0]                      range_low,
  input  logic [31:0]                      range_high,
  input  logic                             res_valid,
  input  logic                             res_stall,
  input  logic [31:0]                      value,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [pcg32_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                      cfg_data,
  output int                               mismatches,
  output int                               outstanding,
  output int                               results_checked
);

  localparam bit [63:0] MULTIPLIER  = 64'd6364136223846793005;
  localparam bit [63:0] START_STATE = 64'h853c49e6748fea9b;
  localparam bit [63:0] START_INC   = 64'hda3e39cb94b95bdb;
  localparam bit [31:0] START_MASK  = 32'h7fffffff;

  bit [63:0] lcg;
  bit [63:0] inc;
  bit [31:0] seed_reg;
  bit [31:0] mask_reg;
  bit [31:0] expected_values[$];

  initial begin
    mismatches      = 0;
    outstanding     = 0;
    results_checked = 0;
  end

  // Step the LCG and return the xorshift-rotate of the old state.
  function automatic bit [31:0] advance();
    bit [63:0] old;
    bit [31:0] folded;
    bit [4:0]  rot;
    old    = lcg;
    lcg    = old * MULTIPLIER + inc;
    folded = 32'((old ^ (old >> 18)) >> 27);
    rot    = old[63:59];
    return (folded >> rot) | (folded << (5'd0 - rot));
  endfunction

  function automatic bit [31:0] predict_value(input pcg32_pkg::mode_t m, input bit [31:0] lo,
                                              input bit [31:0] hi);
    bit [31:0] raw;
    bit [31:0] span;
    predict_value = 32'd0;
    case (m)
      pcg32_pkg::MODE_RAW:    predict_value = advance();
      pcg32_pkg::MODE_MASKED: predict_value = advance() & mask_reg;
      pcg32_pkg::MODE_RANGED: begin
        raw  = advance();
        span = hi - lo + 32'd1;
        predict_value = (span == 32'd0) ? raw + lo : raw % span + lo;
      end
      pcg32_pkg::MODE_RESEED: begin
        lcg = 64'd0;
        inc = {31'd0, seed_reg, 1'b1};
        void'(advance());
        lcg = lcg + {32'd0, seed_reg};
        void'(advance());
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin : watch
    bit [31:0] want;
    if (rst) begin
      lcg      = START_STATE;
      inc      = START_INC;
      seed_reg = 32'd0;
      mask_reg = START_MASK;
      expected_values.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pcg32_pkg::REG_SEED: seed_reg = cfg_data;
          pcg32_pkg::REG_MASK: mask_reg = cfg_data;
          default:  ;
        endcase
      end
      // retire before predicting so a stray result cannot match a fresh request
      if (res_valid && !res_stall) begin
        results_checked <= results_checked + 1;
        if (expected_values.size() == 0) begin
          mismatches <= mismatches + 1;
          $display("%0t: unexpected result, expected none, actual %h", $time, value);
        end else begin
          want = expected_values.pop_front();
          if (value !== want) begin
            mismatches <= mismatches + 1;
            $display("%0t: value mismatch, expected %h, actual %h", $time, want, value);
          end
        end
      end
      if (req_valid && !req_stall)
        expected_values.push_back(predict_value(pcg32_pkg::mode_t'(mode), range_low,
                                                range_high));
    end
    outstanding <= expected_values.size();
  end

endmodule

@@ sim/pcg32_random_generator_tb.sv @@
`timescale 1ns / 100ps
module pcg32_random_generator_tb;

  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_REQUESTS = 175;
  // a little over the spacing between requests
  localparam int DRAIN_CYCLES   = 100;

  // indexes past the register list; writes there must be dropped
  localparam logic [pcg32_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [pcg32_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam logic [31:0] INT_MIN = 32'h8000_0000;
  localparam logic [31:0] INT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

  logic                              clk;
  logic                              rst        = 1'b1;
  logic                              req_valid  = 1'b0;
  logic                              req_stall;
  pcg32_pkg::mode_t                  mode       = pcg32_pkg::MODE_RAW;
  logic signed [31:0]                range_low  = '0;
  logic signed [31:0]                range_high = '0;
  logic                              res_valid;
  logic                              res_stall  = 1'b0;
  logic [31:0]                       value;
  logic                              cfg_valid  = 1'b0;
  logic                              cfg_ready;
  logic [pcg32_pkg::CFG_IDX_W-1:0]   cfg_index  = pcg32_pkg::REG_SEED;
  logic [31:0]                       cfg_data   = '0;

  int mismatches;
  int outstanding;
  int results_checked;
  int cycles = 0;
  int mode_count[4];
  int settings_used = 0;
  // when set, both sides run back to back with no idle cycles
  bit calm = 1'b0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  pcg32_random_generator dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .mode       (mode),
    .range_low  (range_low),
    .range_high (range_high),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .value      (value),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  pcg32_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .mode            (mode),
    .range_low       (range_low),
    .range_high      (range_high),
    .res_valid       (res_valid),
    .res_stall       (res_stall),
    .value           (value),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  // Abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycles, outstanding);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 5);
  endfunction

  // Issue one request after a random gap and hold it until the block takes it.
  // Valid is left high on return; the next call or wait_idle decides whether
  // it drops, so it never falls and rises within one step.
  task automatic send_request(input pcg32_pkg::mode_t m, input logic [31:0] lo,
                              input logic [31:0] hi);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid  <= 1'b1;
    mode       <= m;
    range_low  <= lo;
    range_high <= hi;
    do @(posedge clk); while (req_stall);
    mode_count[int'(m)]++;
  endtask

  // Drop the request line and wait until every predicted result has come back.
  task automatic wait_idle();
    req_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [pcg32_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Reprogram both registers on an idle block, then poke a spare index with
  // junk last so that any aliasing onto a real register would show.
  task automatic load_registers(input logic [31:0] seed, input logic [31:0] msk);
    wait_idle();
    write_reg(pcg32_pkg::REG_SEED, seed);
    write_reg(pcg32_pkg::REG_MASK, msk);
    write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, $urandom());
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Result side: stall for a random stretch ahead of every result, none when calm.
  initial begin : result_sink
    int hold;
    forever begin
      hold = draw_wait();
      if (hold > 0) begin
        res_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      res_stall <= 1'b0;
      do @(posedge clk); while (!(res_valid && !res_stall));
    end
  end

  initial begin : stimulus
    logic [31:0] lo;
    logic [31:0] hi;
    int          pick;
    logic [31:0] seed;
    logic [31:0] msk;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: draws from the power-up state first, so the default state,
    // increment and mask are all checked before anything is reprogrammed.
    send_request(pcg32_pkg::MODE_RAW, 32'd0, 32'd0);
    send_request(pcg32_pkg::MODE_RAW, ALL_ONES, ALL_ONES);     // bounds ignored outside ranged
    send_request(pcg32_pkg::MODE_MASKED, INT_MIN, INT_MAX);    // default mask clears the top bit
    send_request(pcg32_pkg::MODE_RANGED, 32'd0, 32'd0);        // single-value range
    send_request(pcg32_pkg::MODE_RANGED, INT_MIN, INT_MAX);    // full range: span wraps to zero
    send_request(pcg32_pkg::MODE_RANGED, 32'd0, ALL_ONES);     // zero to -1 also wraps
    send_request(pcg32_pkg::MODE_RANGED, 32'd100, -32'sd100);  // inverted bounds: span wraps large
    send_request(pcg32_pkg::MODE_RANGED, 32'd5, 32'd4);        // inverted by one: zero span
    send_request(pcg32_pkg::MODE_RANGED, INT_MAX, INT_MAX);
    send_request(pcg32_pkg::MODE_RANGED, INT_MIN, INT_MIN);
    send_request(pcg32_pkg::MODE_RANGED, INT_MAX, INT_MIN);    // span of two across the wrap
    send_request(pcg32_pkg::MODE_RANGED, -32'sd10, 32'sd10);
    send_request(pcg32_pkg::MODE_RANGED, 32'd0, 32'd1);
    send_request(pcg32_pkg::MODE_RESEED, 32'd0, 32'd0);        // reseed with the reset seed
    send_request(pcg32_pkg::MODE_RAW, 32'd0, 32'd0);

    // extreme register values: all ones for seed and mask
    load_registers(ALL_ONES, ALL_ONES);
    send_request(pcg32_pkg::MODE_RAW, 32'd0, 32'd0);           // reseed has not happened yet
    send_request(pcg32_pkg::MODE_RESEED, ALL_ONES, ALL_ONES);
    send_request(pcg32_pkg::MODE_RAW, 32'd0, 32'd0);
    send_request(pcg32_pkg::MODE_MASKED, 32'd0, 32'd0);

    // and all zeros: masked draws must come back zero
    load_registers(32'd0, 32'd0);
    send_request(pcg32_pkg::MODE_MASKED, 32'd0, 32'd0);
    send_request(pcg32_pkg::MODE_RESEED, 32'd0, 32'd0);
    send_request(pcg32_pkg::MODE_RAW, 32'd0, 32'd0);

    // Random phases, each with its own register setting. Every third phase
    // runs back to back with no idling on either side.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase % 4)
        0: begin seed = $urandom(); msk = $urandom(); end
        1: begin seed = ALL_ONES; msk = 32'd0; end
        2: begin seed = 32'd0; msk = ALL_ONES; end
        default: begin seed = 32'd1 << $urandom_range(0, 31); msk = $urandom() & $urandom(); end
      endcase
      load_registers(seed, msk);
      calm = (phase % 3 == 2);

      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        pick = $urandom_range(0, 99);
        lo   = $urandom();
        hi   = $urandom();
        if (pick < 30) begin
          send_request(pcg32_pkg::MODE_RAW, lo, hi);
        end else if (pick < 55) begin
          send_request(pcg32_pkg::MODE_MASKED, lo, hi);
        end else if (pick < 92) begin
          // shape the bounds: arbitrary pairs are mostly huge or inverted
          case ($urandom_range(0, 5))
            0: ;
            1: hi = lo + $urandom_range(0, 255);
            2: hi = lo + $urandom_range(0, 65535);
            3: hi = lo - 32'd1;                         // zero span
            4: begin
              lo = INT_MIN + $urandom_range(0, 3);
              hi = INT_MAX - $urandom_range(0, 3);
            end
            default: hi = lo + ($urandom() >> $urandom_range(0, 31));
          endcase
          send_request(pcg32_pkg::MODE_RANGED, lo, hi);
        end else begin
          send_request(pcg32_pkg::MODE_RESEED, lo, hi);
        end
      end
    end

    calm = 1'b0;
    wait_idle();
    // hold a while longer so a late stray result still gets flagged
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d raw, %0d masked, %0d ranged and %0d reseed requests",
             mode_count[int'(pcg32_pkg::MODE_RAW)], mode_count[int'(pcg32_pkg::MODE_MASKED)],
             mode_count[int'(pcg32_pkg::MODE_RANGED)],
             mode_count[int'(pcg32_pkg::MODE_RESEED)]);
    $display("over %0d register settings; %0d results compared, %0d mismatches",
             settings_used, results_checked, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
